// ----- design/sct_pkg.sv -----
// ----------------------------------------------------------------------------
// sct_pkg
// Shared widths, command codes and stage enables for the segment collision
// test unit.
// ----------------------------------------------------------------------------
package sct_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int CROSS_W    = PROD_W + 1;
	localparam int CMP_W      = CROSS_W + 1;

	localparam int S_TDATA_W  = 8 * COORD_BITS;
	localparam int M_TDATA_W  = 8;

	localparam logic CMD_SEG = 1'b0;
	localparam logic CMD_BOX = 1'b1;

	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

// ----- design/sct_meet.sv -----
// ----------------------------------------------------------------------------
// sct_meet
// Two-stage segment meeting test: products, then exact cross products, then
// sign and magnitude checks against the determinant.
// ----------------------------------------------------------------------------
module sct_meet (
	input  logic                                    clk,
	input  sct_pkg::stage_en_t                      en,
	input  logic signed [sct_pkg::COORD_BITS-1:0]   kx,
	input  logic signed [sct_pkg::COORD_BITS-1:0]   ky,
	input  logic signed [sct_pkg::COORD_BITS-1:0]   lx,
	input  logic signed [sct_pkg::COORD_BITS-1:0]   ly,
	input  logic signed [sct_pkg::COORD_BITS-1:0]   mx,
	input  logic signed [sct_pkg::COORD_BITS-1:0]   my,
	input  logic signed [sct_pkg::COORD_BITS-1:0]   nx,
	input  logic signed [sct_pkg::COORD_BITS-1:0]   ny,
	output logic                                    hit,
	output logic                                    par
);

	localparam int DW = sct_pkg::DIFF_W;
	localparam int PW = sct_pkg::PROD_W;
	localparam int CW = sct_pkg::CROSS_W;
	localparam int QW = sct_pkg::CMP_W;

	logic signed [DW-1:0] d1x, d1y, d2x, d2y, ex, ey;
	logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [CW-1:0] det, num_a, num_b;
	logic signed [CW-1:0] det_s3, num_a_s3, num_b_s3;
	logic [QW-1:0]        diff_a, diff_b;
	logic                 det_pos, in_a, in_b;

	assign d1x = {lx[$high(lx)], lx} - {kx[$high(kx)], kx};
	assign d1y = {ly[$high(ly)], ly} - {ky[$high(ky)], ky};
	assign d2x = {nx[$high(nx)], nx} - {mx[$high(mx)], mx};
	assign d2y = {ny[$high(ny)], ny} - {my[$high(my)], my};
	assign ex  = {mx[$high(mx)], mx} - {kx[$high(kx)], kx};
	assign ey  = {my[$high(my)], my} - {ky[$high(ky)], ky};

	assign p0 = d2x * d1y;
	assign p1 = d2y * d1x;
	assign p2 = d2x * ey;
	assign p3 = d2y * ex;
	assign p4 = d1x * ey;
	assign p5 = d1y * ex;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p0_s2 <= p0;
			p1_s2 <= p1;
			p2_s2 <= p2;
			p3_s2 <= p3;
			p4_s2 <= p4;
			p5_s2 <= p5;
		end
	end

	assign det   = {p0_s2[PW-1], p0_s2} - {p1_s2[PW-1], p1_s2};
	assign num_a = {p2_s2[PW-1], p2_s2} - {p3_s2[PW-1], p3_s2};
	assign num_b = {p4_s2[PW-1], p4_s2} - {p5_s2[PW-1], p5_s2};

	always_ff @(posedge clk) begin
		if (en.s3) begin
			det_s3   <= det;
			num_a_s3 <= num_a;
			num_b_s3 <= num_b;
		end
	end

	assign diff_a  = {num_a_s3[CW-1], num_a_s3} - {det_s3[CW-1], det_s3};
	assign diff_b  = {num_b_s3[CW-1], num_b_s3} - {det_s3[CW-1], det_s3};
	assign par     = (det_s3 == '0);
	assign det_pos = !det_s3[CW-1];

	always_comb begin
		if (det_pos) begin
			in_a = !num_a_s3[CW-1] && (diff_a[QW-1] || (diff_a == '0));
			in_b = !num_b_s3[CW-1] && (diff_b[QW-1] || (diff_b == '0));
		end else begin
			in_a = (num_a_s3[CW-1] || (num_a_s3 == '0)) && !diff_a[QW-1];
			in_b = (num_b_s3[CW-1] || (num_b_s3 == '0)) && !diff_b[QW-1];
		end
	end

	assign hit = !par && in_a && in_b;

endmodule

// ----- design/segment_collision_test_unit.sv -----
// ----------------------------------------------------------------------------
// segment_collision_test_unit
// Segment against segment, or segment against axis-aligned box, hit test.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one query per request. s_tuser carries the command
//   (segment or box); s_tdata carries the eight signed coordinates.
//   Master channel m_*: one result per query, in query order. m_tdata bit 0
//   is the hit flag, m_tuser flags a zero determinant in segment mode.
//   Path: the input register takes the query at the accepting edge, then the
//   product stage, the cross-product stage and the result register take it
//   in that order.
//   Throughput: one query per cycle unless the receiver stalls; four segment test units run side by
//   side, one for the other segment or for each box edge, each with one
//   multiplier stage.
//   Stall: each stage advances when the next one is empty or moving, so a
//   stalled receiver fills the pipeline; s_tready drops once all four stages
//   hold work, and rises again as soon as m_tready takes a result.
//   Reset: clears every stage valid; no result is pending after reset.
// ----------------------------------------------------------------------------
module segment_collision_test_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// seg_x_start, seg_y_start, seg_x_end, seg_y_end,
	// other_x_a, other_y_a, other_x_b, other_y_b
	input  logic [sct_pkg::S_TDATA_W-1:0]   s_tdata,
	// command
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// hit, zero padding
	output logic [sct_pkg::M_TDATA_W-1:0]   m_tdata,
	// lines_parallel
	output logic                            m_tuser
);

	localparam int CB = sct_pkg::COORD_BITS;
	localparam int NU = 4;

	logic                 valid_s1, valid_s2, valid_s3, out_valid_q;
	logic                 out_free, s3_free, s2_free, s1_free;
	sct_pkg::stage_en_t   en;

	logic                 cmd_s1, cmd_s2, cmd_s3, cmd_q;
	logic signed [CB-1:0] sx0_s1, sy0_s1, sx1_s1, sy1_s1;
	logic signed [CB-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic                 in_box, in_box_s2, in_box_s3;
	logic                 hit_q, par_q;

	logic signed [CB-1:0] mx [NU];
	logic signed [CB-1:0] my [NU];
	logic signed [CB-1:0] nx [NU];
	logic signed [CB-1:0] ny [NU];
	logic [NU-1:0]        u_hit, u_par;
	logic                 hit_d;

	assign out_free = !out_valid_q || m_tready;
	assign s3_free  = !valid_s3 || out_free;
	assign s2_free  = !valid_s2 || s3_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign s_tready = s1_free;
	assign en.s2    = s2_free && valid_s1;
	assign en.s3    = s3_free && valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free)  valid_s1    <= s_tvalid;
			if (s2_free)  valid_s2    <= valid_s1;
			if (s3_free)  valid_s3    <= valid_s2;
			if (out_free) out_valid_q <= valid_s3;
		end
	end

	// capture query
	always_ff @(posedge clk) begin
		if (s1_free && s_tvalid) begin
			cmd_s1 <= s_tuser;
			sx0_s1 <= s_tdata[0*CB +: CB];
			sy0_s1 <= s_tdata[1*CB +: CB];
			sx1_s1 <= s_tdata[2*CB +: CB];
			sy1_s1 <= s_tdata[3*CB +: CB];
			ax_s1  <= s_tdata[4*CB +: CB];
			ay_s1  <= s_tdata[5*CB +: CB];
			bx_s1  <= s_tdata[6*CB +: CB];
			by_s1  <= s_tdata[7*CB +: CB];
		end
	end

	assign in_box =
		(sx0_s1 >= ax_s1 && sx0_s1 <= bx_s1 && sy0_s1 >= ay_s1 && sy0_s1 <= by_s1) ||
		(sx1_s1 >= ax_s1 && sx1_s1 <= bx_s1 && sy1_s1 >= ay_s1 && sy1_s1 <= by_s1);

	// unit 0 takes the other segment or the bottom edge; the rest take box edges
	always_comb begin
		mx[0] = ax_s1;
		my[0] = ay_s1;
		nx[0] = bx_s1;
		ny[0] = (cmd_s1 == sct_pkg::CMD_BOX) ? ay_s1 : by_s1;
		mx[1] = bx_s1;
		my[1] = ay_s1;
		nx[1] = bx_s1;
		ny[1] = by_s1;
		mx[2] = ax_s1;
		my[2] = ay_s1;
		nx[2] = ax_s1;
		ny[2] = by_s1;
		mx[3] = ax_s1;
		my[3] = by_s1;
		nx[3] = bx_s1;
		ny[3] = by_s1;
	end

	for (genvar g = 0; g < NU; g++) begin : g_unit
		sct_meet u_meet (
			.clk (clk),
			.en  (en),
			.kx  (sx0_s1),
			.ky  (sy0_s1),
			.lx  (sx1_s1),
			.ly  (sy1_s1),
			.mx  (mx[g]),
			.my  (my[g]),
			.nx  (nx[g]),
			.ny  (ny[g]),
			.hit (u_hit[g]),
			.par (u_par[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			cmd_s2    <= cmd_s1;
			in_box_s2 <= in_box;
		end
		if (en.s3) begin
			cmd_s3    <= cmd_s2;
			in_box_s3 <= in_box_s2;
		end
	end

	always_comb begin
		case (cmd_s3)
			sct_pkg::CMD_SEG: hit_d = u_hit[0];
			sct_pkg::CMD_BOX: hit_d = in_box_s3 || (|u_hit);
			default:          hit_d = 1'b0;
		endcase
	end

	// hold result until taken
	always_ff @(posedge clk) begin
		if (out_free && valid_s3) begin
			cmd_q <= cmd_s3;
			hit_q <= hit_d;
			par_q <= (cmd_s3 == sct_pkg::CMD_SEG) && u_par[0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(sct_pkg::M_TDATA_W-1){1'b0}}, hit_q};
	assign m_tuser  = par_q;

`ifndef SYNTH
	a_box_not_parallel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (cmd_q == sct_pkg::CMD_BOX) |-> !par_q)
		else $error("box result flagged parallel");

	a_parallel_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && par_q |-> !hit_q)
		else $error("parallel result reported as hit");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty result register");

	a_s2_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !s3_free |=> valid_s2)
		else $error("stage two item lost while stalled");
`endif

endmodule

// ----- dv/segment_collision_test_unit_tb.sv -----
// ----------------------------------------------------------------------------
// segment_collision_test_unit_tb
// Drives segment and box collision queries through the stream ports and
// checks every result against an exact integer predictor. Random idle gaps
// are applied on both channels. The run covers directed corner cases, then
// random segment pairs and boxes, drain pauses, and full-rate bursts.
// ----------------------------------------------------------------------------
module segment_collision_test_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int   CB      = sct_pkg::COORD_BITS;
	localparam logic CMD_SEG = sct_pkg::CMD_SEG;
	localparam logic CMD_BOX = sct_pkg::CMD_BOX;

	typedef logic signed [CB-1:0] coord_t;

	// packed from the top down, so seg x start lands in the lowest bits of tdata
	typedef struct packed {
		coord_t oyb;
		coord_t oxb;
		coord_t oya;
		coord_t oxa;
		coord_t sye;
		coord_t sxe;
		coord_t sys;
		coord_t sxs;
	} coords_t;

	typedef struct packed {
		logic hit;
		logic parallel;
	} verdict_t;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [sct_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
	logic                           s_tuser  = CMD_SEG;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [sct_pkg::M_TDATA_W-1:0]  m_tdata;
	logic                           m_tuser;

	verdict_t verdict_q[$];
	verdict_t want;
	int       mismatches  = 0;
	int       n_seg       = 0;
	int       n_box       = 0;
	int       n_hit       = 0;
	int       n_par       = 0;
	int       n_results   = 0;
	int       stall_left  = 0;
	bit       sender_idles = 1'b1;
	bit       sink_stalls  = 1'b1;

	segment_collision_test_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic in_span(longint num, longint den);
		if (den > 0) begin
			return num >= 0 && num - den <= 0;
		end
		return num <= 0 && num - den >= 0;
	endfunction

	function automatic logic segments_meet(longint kx, longint ky, longint lx, longint ly,
			longint mx, longint my, longint nx, longint ny, output logic par);
		longint d1x, d1y, d2x, d2y, ex, ey, det;
		d1x = lx - kx;
		d1y = ly - ky;
		d2x = nx - mx;
		d2y = ny - my;
		ex  = mx - kx;
		ey  = my - ky;
		det = d2x * d1y - d2y * d1x;
		par = det == 0;
		if (par) begin
			return 1'b0;
		end
		return in_span(d2x * ey - d2y * ex, det) && in_span(d1x * ey - d1y * ex, det);
	endfunction

	function automatic logic point_in_box(longint x, longint y, longint x0, longint y0,
			longint x1, longint y1);
		return x >= x0 && x <= x1 && y >= y0 && y <= y1;
	endfunction

	function automatic verdict_t predict_collision(logic cmd, coords_t q);
		longint   sx0, sy0, sx1, sy1, ax, ay, bx, by;
		logic     par;
		verdict_t v;
		sx0 = $signed(q.sxs);
		sy0 = $signed(q.sys);
		sx1 = $signed(q.sxe);
		sy1 = $signed(q.sye);
		ax  = $signed(q.oxa);
		ay  = $signed(q.oya);
		bx  = $signed(q.oxb);
		by  = $signed(q.oyb);
		v   = '0;
		if (cmd == CMD_SEG) begin
			v.hit      = segments_meet(sx0, sy0, sx1, sy1, ax, ay, bx, by, par);
			v.parallel = par;
			return v;
		end
		v.hit = point_in_box(sx0, sy0, ax, ay, bx, by) || point_in_box(sx1, sy1, ax, ay, bx, by);
		if (!v.hit) begin
			v.hit = segments_meet(sx0, sy0, sx1, sy1, ax, ay, bx, ay, par) ||
				segments_meet(sx0, sy0, sx1, sy1, bx, ay, bx, by, par) ||
				segments_meet(sx0, sy0, sx1, sy1, ax, ay, ax, by, par) ||
				segments_meet(sx0, sy0, sx1, sy1, ax, by, bx, by, par);
		end
		return v;
	endfunction

	// ---------------------------------------------------------------- checker

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (verdict_q.size() == 0) begin
					report_mismatch("result with no request pending");
				end else begin
					want = verdict_q.pop_front();
					if (m_tdata[0] !== want.hit) begin
						report_mismatch($sformatf("hit %b, predicted %b", m_tdata[0], want.hit));
					end
					if (m_tuser !== want.parallel) begin
						report_mismatch($sformatf("lines_parallel %b, predicted %b",
							m_tuser, want.parallel));
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else if (sink_stalls && $urandom_range(0, 99) < 25) begin
				stall_left <= pick_gap();
				m_tready   <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- sender

	task automatic send_query(logic cmd, coords_t q);
		int       gap;
		verdict_t v;
		gap = sender_idles ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= q;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		v = predict_collision(cmd, q);
		verdict_q = {verdict_q, v};
		if (cmd == CMD_SEG) n_seg++;
		else n_box++;
		if (v.hit) n_hit++;
		if (v.parallel) n_par++;
	endtask

	task automatic send_coords(logic cmd, int sxs, int sys, int sxe, int sye,
			int oxa, int oya, int oxb, int oyb);
		coords_t q;
		q.sxs = coord_t'(sxs);
		q.sys = coord_t'(sys);
		q.sxe = coord_t'(sxe);
		q.sye = coord_t'(sye);
		q.oxa = coord_t'(oxa);
		q.oya = coord_t'(oya);
		q.oxb = coord_t'(oxb);
		q.oyb = coord_t'(oyb);
		send_query(cmd, q);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- generators

	function automatic coord_t near(int c, int span);
		return coord_t'(c + $urandom_range(0, 2 * span) - span);
	endfunction

	function automatic coord_t pick_edge();
		case ($urandom_range(0, 6))
			0: return coord_t'(-32768);
			1: return coord_t'(-32767);
			2: return coord_t'(-1);
			3: return coord_t'(0);
			4: return coord_t'(1);
			5: return coord_t'(32766);
			default: return coord_t'(32767);
		endcase
	endfunction

	function automatic coords_t full_range_coords();
		coords_t q;
		q = {$urandom, $urandom, $urandom, $urandom};
		return q;
	endfunction

	function automatic coords_t edge_coords();
		coords_t q;
		q.sxs = pick_edge();
		q.sys = pick_edge();
		q.sxe = pick_edge();
		q.sye = pick_edge();
		q.oxa = pick_edge();
		q.oya = pick_edge();
		q.oxb = pick_edge();
		q.oyb = pick_edge();
		return q;
	endfunction

	function automatic coords_t make_segment_pair();
		coords_t q;
		int      r, cx, cy, span, dx, dy, k;
		r    = $urandom_range(0, 99);
		cx   = $urandom_range(0, 32000) - 16000;
		cy   = $urandom_range(0, 32000) - 16000;
		span = $urandom_range(4, 4096);
		if (r < 50) begin
			q.sxs = near(cx, span);
			q.sys = near(cy, span);
			q.sxe = near(cx, span);
			q.sye = near(cy, span);
			q.oxa = near(cx, span);
			q.oya = near(cy, span);
			q.oxb = near(cx, span);
			q.oyb = near(cy, span);
		end else if (r < 65) begin
			q = full_range_coords();
		end else if (r < 75) begin
			q = edge_coords();
		end else if (r < 90) begin
			// parallel or collinear pair
			dx    = $urandom_range(0, 400) - 200;
			dy    = $urandom_range(0, 400) - 200;
			k     = $urandom_range(0, 3) - 2;
			q.sxs = coord_t'(cx);
			q.sys = coord_t'(cy);
			q.sxe = coord_t'(cx + dx);
			q.sye = coord_t'(cy + dy);
			if ($urandom_range(0, 1)) begin
				q.oxa = coord_t'(cx + dx * $urandom_range(0, 3));
				q.oya = coord_t'(cy + dy * $urandom_range(0, 3));
			end else begin
				q.oxa = near(cx, 64);
				q.oya = near(cy, 64);
			end
			q.oxb = coord_t'(int'(q.oxa) + k * dx);
			q.oyb = coord_t'(int'(q.oya) + k * dy);
		end else begin
			// second segment usually starts on an endpoint of the first
			q.sxs = near(cx, span);
			q.sys = near(cy, span);
			q.sxe = near(cx, span);
			q.sye = near(cy, span);
			q.oxa = $urandom_range(0, 1) ? q.sxe : q.sxs;
			q.oya = ($urandom_range(0, 3) == 0) ? near(cy, span) :
				((q.oxa == q.sxe) ? q.sye : q.sys);
			q.oxb = near(cx, span);
			q.oyb = near(cy, span);
		end
		return q;
	endfunction

	function automatic coords_t make_box_query();
		coords_t q;
		int      r, cx, cy, w, h, span;
		r    = $urandom_range(0, 99);
		cx   = $urandom_range(0, 32000) - 16000;
		cy   = $urandom_range(0, 32000) - 16000;
		w    = $urandom_range(0, 1024);
		h    = $urandom_range(0, 1024);
		span = $urandom_range(8, 3000);
		if (r < 70) begin
			q.oxa = coord_t'(cx - w);
			q.oya = coord_t'(cy - h);
			q.oxb = coord_t'(cx + w);
			q.oyb = coord_t'(cy + h);
			if (r < 10) begin
				q.oxa = coord_t'(cx + w + 1);
				q.oxb = coord_t'(cx - w);
			end else if (r < 15) begin
				q.oya = coord_t'(cy + h + 1);
				q.oyb = coord_t'(cy - h);
			end else if (r < 20) begin
				q.oxb = q.oxa;
			end
			q.sxs = near(cx, span);
			q.sys = near(cy, span);
			q.sxe = near(cx, span);
			q.sye = near(cy, span);
			// occasionally slide along an edge line
			if (r >= 60) begin
				q.sys = q.oya;
				q.sye = q.oya;
			end
		end else if (r < 85) begin
			q = full_range_coords();
		end else begin
			q = edge_coords();
		end
		return q;
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		send_coords(CMD_SEG, -256, -256, 256, 256, -256, 256, 256, -256);
		send_coords(CMD_SEG, -32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_coords(CMD_SEG, 0, 0, 256, 0, 0, 0, 0, 256);
		send_coords(CMD_SEG, 0, 0, 256, 0, 256, -256, 256, 256);
		send_coords(CMD_SEG, 0, 0, 256, 0, 257, -256, 257, 256);
		send_coords(CMD_SEG, 0, 0, 256, 0, 0, 1, 256, 1);
		send_coords(CMD_SEG, 0, 0, 256, 0, 128, 0, 512, 0);
		send_coords(CMD_SEG, 5, 5, 5, 5, 0, 0, 10, 10);
		send_coords(CMD_SEG, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send_coords(CMD_SEG, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_coords(CMD_SEG, 32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
		send_coords(CMD_BOX, 0, 0, 1000, 1000, -10, -10, 10, 10);
		send_coords(CMD_BOX, 10, 10, 500, 500, -10, -10, 10, 10);
		send_coords(CMD_BOX, -100, 0, 100, 0, -10, -10, 10, 10);
		send_coords(CMD_BOX, 20, 20, 30, 40, -10, -10, 10, 10);
		send_coords(CMD_BOX, -100, 0, 100, 0, 10, 10, -10, -10);
		send_coords(CMD_BOX, 0, 0, 1, 1, 10, 10, -10, -10);
		send_coords(CMD_BOX, -100, -10, 100, -10, -10, -10, 10, 10);
		send_coords(CMD_BOX, -100, -10, -20, -10, -10, -10, 10, 10);
		send_coords(CMD_BOX, -5, 0, 5, 0, 0, 0, 0, 0);
		send_coords(CMD_BOX, 32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767);
		send_coords(CMD_BOX, 100, 100, 100, 100, -10, -10, 10, 10);
		send_coords(CMD_BOX, 3, 3, 3, 3, -10, -10, 10, 10);
		send_coords(CMD_BOX, -32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768);
	endtask

	task automatic test_random_segments(int n);
		repeat (n) send_query(CMD_SEG, make_segment_pair());
	endtask

	task automatic test_random_boxes(int n);
		repeat (n) send_query(CMD_BOX, make_box_query());
	endtask

	task automatic test_drain_pause();
		repeat (10) begin
			repeat (10) begin
				if ($urandom_range(0, 1)) send_query(CMD_SEG, make_segment_pair());
				else send_query(CMD_BOX, make_box_query());
			end
			wait_for_drain();
		end
	endtask

	task automatic test_back_to_back();
		sender_idles = 1'b0;
		sink_stalls  = 1'b0;
		repeat (60) begin
			if ($urandom_range(0, 1)) send_query(CMD_SEG, make_segment_pair());
			else send_query(CMD_BOX, make_box_query());
		end
		sink_stalls = 1'b1;
		repeat (60) begin
			if ($urandom_range(0, 1)) send_query(CMD_SEG, make_segment_pair());
			else send_query(CMD_BOX, make_box_query());
		end
		sender_idles = 1'b1;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_segments(400);
		test_random_boxes(400);
		test_drain_pause();
		test_back_to_back();
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Checked %0d results: %0d segment pairs, %0d box queries.",
			n_results, n_seg, n_box);
		$display("Predicted %0d hits and %0d parallel cases.", n_hit, n_par);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/sct_pkg.sv
design/sct_meet.sv
design/segment_collision_test_unit.sv
dv/segment_collision_test_unit_tb.sv
